FILE: rtl/ttg_pkg.sv
package ttg_pkg;

    localparam int TIME_W  = 64;
    localparam int TOTAL_W = 40;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = 40'hFF_FFFF_FFFF;
    localparam logic [TIME_W-1:0]  HOUR_US   = 64'd3600 * 64'd1000000;

    typedef enum logic [2:0] {
        OP_PTT_ON  = 3'd0,
        OP_PTT_OFF = 3'd1,
        OP_TICK    = 3'd2,
        OP_QUERY   = 3'd3,
        OP_OPER    = 3'd4,
        OP_DEADMAN = 3'd5,
        OP_ARM     = 3'd6,
        OP_DISARM  = 3'd7
    } t_opcode;

    typedef enum logic [1:0] {
        REG_SESSION_LIMIT = 2'd0,
        REG_SLOT_LIMIT    = 2'd1,
        REG_PTT_TIMEOUT   = 2'd2,
        REG_INACT_TIMEOUT = 2'd3
    } t_reg_idx;

    // Request to the shared adder/subtractor
    typedef struct packed {
        logic [TIME_W-1:0] a;
        logic [TIME_W-1:0] b;
        logic              sub;
    } t_alu_req;

endpackage

FILE: rtl/ttg_alu.sv
module ttg_alu (
    input  ttg_pkg::t_alu_req          i_req,
    output logic [ttg_pkg::TIME_W:0]   o_res
);

    logic [ttg_pkg::TIME_W:0] w_b;

    // Subtract as a + ~b + 1; the top bit is then the no-borrow flag (a >= b)
    assign w_b   = {1'b0, (i_req.sub ? ~i_req.b : i_req.b)};
    assign o_res = {1'b0, i_req.a} + w_b + (ttg_pkg::TIME_W + 1)'(i_req.sub);

endmodule

FILE: rtl/transmit_time_guard.sv
// Transmit time guard: one event item in, one result item out. PTT on, arm,
// disarm and operator input go straight to the result register. PTT off adds
// a difference and an accumulate step, dead-man tick a difference and a check
// step, watchdog tick a difference, a check and, on timeout, an accumulate
// step; all three go straight to the result when there is nothing to time
// (PTT already off, guard disarmed or inactivity timeout zero). A budget query
// compares the session total with its limit, then the single 65-bit
// adder/subtractor walks the slot ring one entry a cycle through the ring's
// one registered read port. The input is not ready while an item is at work;
// a finished result waits in the output register while the next item is taken.
module transmit_time_guard #(
    parameter int SLOT_HISTORY = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // [2:0] opcode, [66:3] time_us
    input  logic [71:0] s_axis_tdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [0] budget_ok, [1] force_ptt_off, [2] dead_man_fired, [3] ptt_active,
    // [4] armed_now, [44:5] session_tx_total_us, [49:45] slots_last_hour
    output logic [55:0] m_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    localparam int PTR_W = (SLOT_HISTORY > 1) ? $clog2(SLOT_HISTORY) : 1;
    localparam int CNT_W = $clog2(SLOT_HISTORY + 1);
    localparam int CW    = (CNT_W > 5) ? CNT_W : 5;
    localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;
    localparam int TW    = ttg_pkg::TIME_W;
    localparam int SW    = ttg_pkg::TOTAL_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIFF,
        S_CHK,
        S_ACCUM,
        S_QLIM,
        S_QRUN,
        S_QFIN,
        S_DONE
    } t_state;

    t_state r_state;

    // Configuration
    logic [SW-1:0] r_cfg_session;
    logic [7:0]    r_cfg_slots;
    logic [31:0]   r_cfg_ptt_to;
    logic [31:0]   r_cfg_inact;

    // Guard state
    logic [TW-1:0]    r_slot_mem [SLOT_HISTORY];
    logic [PTR_W-1:0] r_wptr;
    logic [CNT_W-1:0] r_filled;
    logic             r_ptt_on;
    logic [TW-1:0]    r_ptt_start;
    logic [SW-1:0]    r_total;
    logic             r_armed;
    logic [TW-1:0]    r_last_op;

    // Item in flight
    ttg_pkg::t_opcode r_op;
    logic [TW-1:0]    r_now;
    logic [TW:0]      r_acc;
    logic             r_ok;
    logic             r_forced;
    logic             r_fired;
    logic             r_lim_hit;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] r_rd_idx;
    logic             r_rd_vld;
    logic             r_df_vld;
    logic [TW-1:0]    r_rd_data;

    logic [55:0] r_out_data;
    logic        r_out_valid;

    ttg_pkg::t_alu_req w_req;
    logic [TW:0]       w_res;
    logic              w_accept;
    ttg_pkg::t_opcode  w_op;
    logic [TW-1:0]     w_time;
    logic              w_wr_en;
    logic              w_rd_en;
    logic              w_sat;
    logic [SW-1:0]     w_new_total;
    logic [CW-1:0]     w_cnt_ext;
    logic [4:0]        w_slots;
    logic              w_slot_hit;
    logic              w_cfg_wr;

    assign w_accept = s_axis_tvalid && s_axis_tready;
    assign w_op     = ttg_pkg::t_opcode'(s_axis_tdata[2:0]);
    assign w_time   = s_axis_tdata[66:3];
    assign w_wr_en  = w_accept && (w_op == ttg_pkg::OP_PTT_ON);
    assign w_rd_en  = (r_state == S_QRUN) && (r_rd_idx < r_filled);

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign pready        = 1'b1;
    assign w_cfg_wr      = psel && penable && pwrite;

    always_comb begin
        unique case (ttg_pkg::t_reg_idx'(paddr[4:3]))
            ttg_pkg::REG_SESSION_LIMIT: prdata = 64'(r_cfg_session);
            ttg_pkg::REG_SLOT_LIMIT:    prdata = 64'(r_cfg_slots);
            ttg_pkg::REG_PTT_TIMEOUT:   prdata = 64'(r_cfg_ptt_to);
            ttg_pkg::REG_INACT_TIMEOUT: prdata = 64'(r_cfg_inact);
            default:                    prdata = '0;
        endcase
    end

    // Drive the shared unit from the sequencer state
    always_comb begin
        w_req = '0;
        unique case (r_state)
            S_DIFF: begin
                w_req.a   = r_now;
                w_req.b   = (r_op == ttg_pkg::OP_DEADMAN) ? r_last_op : r_ptt_start;
                w_req.sub = 1'b1;
            end
            S_CHK: begin
                w_req.a   = r_acc[TW-1:0];
                w_req.b   = (r_op == ttg_pkg::OP_DEADMAN) ? TW'(r_cfg_inact)
                                                          : TW'(r_cfg_ptt_to);
                w_req.sub = 1'b1;
            end
            S_ACCUM: begin
                w_req.a   = TW'(r_total);
                w_req.b   = r_acc[TW-1:0];
                w_req.sub = 1'b0;
            end
            S_QLIM: begin
                w_req.a   = TW'(r_total);
                w_req.b   = TW'(r_cfg_session);
                w_req.sub = 1'b1;
            end
            S_QRUN: begin
                w_req.a   = r_now;
                w_req.b   = r_rd_data;
                w_req.sub = 1'b1;
            end
            default: w_req = '0;
        endcase
    end

    ttg_alu u_alu (
        .i_req (w_req),
        .o_res (w_res)
    );

    // Saturate when total + elapsed reaches the maximum
    assign w_sat       = (|w_res[TW:SW]) || (&w_res[SW-1:0]);
    assign w_new_total = w_sat ? ttg_pkg::TOTAL_MAX : w_res[SW-1:0];

    assign w_cnt_ext  = CW'(r_cnt);
    assign w_slots    = (w_cnt_ext > CW'(31)) ? 5'd31 : w_cnt_ext[4:0];
    assign w_slot_hit = (r_cfg_slots != 8'd0) && (CMP_W'(r_cnt) >= CMP_W'(r_cfg_slots));

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_slot_mem[r_wptr] <= w_time;
        end
        if (w_rd_en) begin
            r_rd_data <= r_slot_mem[r_rd_idx[PTR_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_session <= '0;
            r_cfg_slots   <= '0;
            r_cfg_ptt_to  <= '0;
            r_cfg_inact   <= '0;
        end else if (w_cfg_wr) begin
            unique case (ttg_pkg::t_reg_idx'(paddr[4:3]))
                ttg_pkg::REG_SESSION_LIMIT: r_cfg_session <= pwdata[SW-1:0];
                ttg_pkg::REG_SLOT_LIMIT:    r_cfg_slots   <= pwdata[7:0];
                ttg_pkg::REG_PTT_TIMEOUT:   r_cfg_ptt_to  <= pwdata[31:0];
                ttg_pkg::REG_INACT_TIMEOUT: r_cfg_inact   <= pwdata[31:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wptr      <= '0;
            r_filled    <= '0;
            r_ptt_on    <= 1'b0;
            r_ptt_start <= '0;
            r_total     <= '0;
            r_armed     <= 1'b0;
            r_last_op   <= '0;
            r_rd_vld    <= 1'b0;
            r_df_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // S_DONE drives the output valid itself
            if (m_axis_tready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_op      <= w_op;
                        r_now     <= w_time;
                        r_ok      <= 1'b0;
                        r_forced  <= 1'b0;
                        r_fired   <= 1'b0;
                        r_lim_hit <= 1'b0;
                        r_cnt     <= '0;
                        unique case (w_op)
                            ttg_pkg::OP_PTT_ON: begin
                                r_ptt_on    <= 1'b1;
                                r_ptt_start <= w_time;
                                r_wptr <= (r_wptr == PTR_W'(SLOT_HISTORY - 1)) ? '0
                                                                               : r_wptr + 1'b1;
                                if (r_filled != CNT_W'(SLOT_HISTORY)) begin
                                    r_filled <= r_filled + 1'b1;
                                end
                                r_state <= S_DONE;
                            end
                            ttg_pkg::OP_PTT_OFF, ttg_pkg::OP_TICK: begin
                                r_state <= r_ptt_on ? S_DIFF : S_DONE;
                            end
                            ttg_pkg::OP_QUERY: begin
                                r_state <= S_QLIM;
                            end
                            ttg_pkg::OP_OPER: begin
                                r_last_op <= w_time;
                                r_state   <= S_DONE;
                            end
                            ttg_pkg::OP_DEADMAN: begin
                                r_state <= (r_armed && (r_cfg_inact != 32'd0)) ? S_DIFF
                                                                               : S_DONE;
                            end
                            ttg_pkg::OP_ARM: begin
                                r_armed   <= 1'b1;
                                r_last_op <= w_time;
                                r_state   <= S_DONE;
                            end
                            ttg_pkg::OP_DISARM: begin
                                r_armed <= 1'b0;
                                r_state <= S_DONE;
                            end
                            default: r_state <= S_DONE;
                        endcase
                    end
                end
                S_DIFF: begin
                    r_acc   <= w_res;
                    r_state <= (r_op == ttg_pkg::OP_PTT_OFF) ? S_ACCUM : S_CHK;
                end
                S_CHK: begin
                    if (w_res[TW]) begin
                        if (r_op == ttg_pkg::OP_DEADMAN) begin
                            r_armed <= 1'b0;
                            r_fired <= 1'b1;
                            r_state <= S_DONE;
                        end else begin
                            r_forced <= 1'b1;
                            r_state  <= S_ACCUM;
                        end
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_ACCUM: begin
                    r_total  <= w_new_total;
                    r_ptt_on <= 1'b0;
                    r_state  <= S_DONE;
                end
                S_QLIM: begin
                    r_lim_hit <= (r_cfg_session != '0) && w_res[TW];
                    r_rd_idx  <= '0;
                    r_rd_vld  <= 1'b0;
                    r_df_vld  <= 1'b0;
                    r_state   <= S_QRUN;
                end
                S_QRUN: begin
                    // read, subtract and compare run one entry apart
                    if (w_rd_en) begin
                        r_rd_idx <= r_rd_idx + 1'b1;
                    end
                    r_rd_vld <= w_rd_en;
                    r_df_vld <= r_rd_vld;
                    if (r_rd_vld) begin
                        r_acc <= w_res;
                    end
                    if (r_df_vld && (r_acc[TW-1:0] < ttg_pkg::HOUR_US)) begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                    if (!w_rd_en && !r_rd_vld && !r_df_vld) begin
                        r_state <= S_QFIN;
                    end
                end
                S_QFIN: begin
                    r_ok    <= !r_lim_hit && !w_slot_hit;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_data  <= {6'd0,
                                        (r_op == ttg_pkg::OP_QUERY) ? w_slots : 5'd0,
                                        r_total, r_armed, r_ptt_on,
                                        r_fired, r_forced, r_ok};
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_filled_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_filled <= CNT_W'(SLOT_HISTORY))
        else $error("slot fill count beyond ring depth");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !s_axis_tready)
        else $error("input ready right after an accepted item");

    a_forced_releases: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[1] |-> !m_axis_tdata[3])
        else $error("forced release reported with PTT still active");

    a_fired_disarms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[2] |-> !m_axis_tdata[4])
        else $error("dead-man fire reported while still armed");

    a_total_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_total >= $past(r_total)))
        else $error("session total decreased");

endmodule
